[rtl/tsam_pkg.sv]
`default_nettype none

package tsam_pkg;

  // Field widths.
  localparam int SAMPLE_W   = 16;
  localparam int CAL_W      = 16;
  localparam int SPAN_W     = 12;
  localparam int AXIS_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = CAL_W + SPAN_W;

  // Default burst shape.
  localparam int DISCARD_DEF = 5;
  localparam int AVERAGE_DEF = 8;

  // Axis codes.
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_P = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd5;

  // Configuration reset values.
  localparam logic [CAL_W-1:0]  X_LOW_RST  = 16'd3300;
  localparam logic [CAL_W-1:0]  X_HIGH_RST = 16'd28600;
  localparam logic [CAL_W-1:0]  Y_LOW_RST  = 16'd4100;
  localparam logic [CAL_W-1:0]  Y_HIGH_RST = 16'd29000;
  localparam logic [SPAN_W-1:0] WIDTH_RST  = 12'd240;
  localparam logic [SPAN_W-1:0] HEIGHT_RST = 12'd320;

  typedef struct packed {
    logic [CAL_W-1:0]  x_low;
    logic [CAL_W-1:0]  x_high;
    logic [CAL_W-1:0]  y_low;
    logic [CAL_W-1:0]  y_high;
    logic [SPAN_W-1:0] width;
    logic [SPAN_W-1:0] height;
  } cal_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_MAP,
    BK_MUL,
    BK_LAUNCH,
    BK_POS,
    BK_FIN,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/tsam_front.sv]
`default_nettype none

module tsam_front #(
  parameter int DISCARD = tsam_pkg::DISCARD_DEF,
  parameter int AVERAGE = tsam_pkg::AVERAGE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [tsam_pkg::AXIS_W-1:0]   in_kind,
  input  wire logic [tsam_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          in_start_req,
  input  wire logic                          full_i,
  output logic                               push_o,
  output logic [tsam_pkg::AXIS_W-1:0]        push_axis_o,
  output logic [tsam_pkg::SAMPLE_W+$clog2(AVERAGE)-1:0] push_sum_o
);

  localparam int TOTAL = DISCARD + AVERAGE;
  localparam int CNT_W = $clog2(TOTAL + 1);
  localparam int SUM_W = tsam_pkg::SAMPLE_W + $clog2(AVERAGE);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt, cnt_base, cnt_inc;
  logic [SUM_W-1:0]            sum_r, sum_nxt, sum_base, sum_add;
  logic [tsam_pkg::AXIS_W-1:0] axis_r, axis_nxt, axis_base;
  logic                        accept, active;

  always_comb begin
    in_ready  = !full_i;
    accept    = in_valid && in_ready;
    cnt_base  = cnt_r;
    sum_base  = sum_r;
    axis_base = axis_r;
    active    = 1'b1;
    if (in_start_req) begin
      cnt_base  = '0;
      sum_base  = '0;
      axis_base = (in_kind > tsam_pkg::AXIS_P) ? tsam_pkg::AXIS_P : in_kind;
    end else if (cnt_r >= CNT_W'(TOTAL)) begin
      active = 1'b0;
    end
    // Samples past the discard window go into the running sum.
    sum_add = (cnt_base >= CNT_W'(DISCARD)) ?
              sum_base + SUM_W'(in_sample) : sum_base;
    cnt_inc = cnt_base + CNT_W'(1);

    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    axis_nxt = axis_r;
    push_o   = 1'b0;
    if (accept && active) begin
      cnt_nxt  = cnt_inc;
      sum_nxt  = sum_add;
      axis_nxt = axis_base;
      push_o   = (cnt_inc == CNT_W'(TOTAL));
    end
    push_axis_o = axis_base;
    push_sum_o  = sum_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      axis_r <= tsam_pkg::AXIS_X;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      axis_r <= axis_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TOTAL))
    else $error("burst counter ran past the burst length");

endmodule

`default_nettype wire

[rtl/tsam_fifo.sv]
`default_nettype none

module tsam_fifo #(
  parameter int W = tsam_pkg::AXIS_W + tsam_pkg::SAMPLE_W
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      pop_data_o
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   count_r;

  always_comb begin
    full_o     = (count_r == 2'd2);
    valid_o    = (count_r != 2'd0);
    pop_data_o = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_i) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

[rtl/tsam_div.sv]
`default_nettype none

module tsam_div #(
  parameter int W  = tsam_pkg::PROD_W,
  parameter int DW = tsam_pkg::CAL_W
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [W-1:0]       quotient_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     quo_r;
  logic [DW-1:0]    rem_r, dvs_r, rem_step;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r, ge;
  logic [DW:0]      trial;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    rem_step = ge ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      quo_r <= {quo_r[W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_r;
  assign done_o     = done_r;
  assign quotient_o = quo_r;

endmodule

`default_nettype wire

[rtl/tsam_back.sv]
`default_nettype none

module tsam_back #(
  parameter int AVERAGE = tsam_pkg::AVERAGE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tsam_pkg::cal_cfg_t                cfg_i,
  input  wire logic                              q_valid_i,
  output logic                                   q_pop_o,
  input  wire logic [tsam_pkg::AXIS_W-1:0]       q_axis_i,
  input  wire logic [tsam_pkg::SAMPLE_W+$clog2(AVERAGE)-1:0] q_sum_i,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tsam_pkg::AXIS_W-1:0]            out_axis,
  output logic [tsam_pkg::SAMPLE_W-1:0]          out_raw_average,
  output logic [tsam_pkg::SPAN_W-1:0]            out_position
);

  localparam int PW = tsam_pkg::PROD_W;
  localparam int CW = tsam_pkg::CAL_W;
  localparam int SW = tsam_pkg::SPAN_W;

  // The mean is the burst sum times a rounded-up reciprocal of AVERAGE,
  // shifted right. With RSH = sum width + ceil(log2(AVERAGE)) the result is
  // the exact truncated quotient for every sum the front end can produce.
  localparam int SUM_W = tsam_pkg::SAMPLE_W + $clog2(AVERAGE);
  localparam int RSH   = SUM_W + $clog2(AVERAGE);
  localparam int RW    = SUM_W + 1;
  localparam int MW    = 2 * SUM_W + 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << RSH) + 64'(AVERAGE) - 64'd1) / 64'(AVERAGE));

  tsam_pkg::back_state_t        state_r, state_nxt;
  logic [tsam_pkg::AXIS_W-1:0]  axis_r, axis_nxt;
  logic [tsam_pkg::SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [CW-1:0]                diff_r, diff_nxt, den_r, den_nxt, lo, hi;
  logic [SW-1:0]                span_r, span_nxt, span_sel;
  logic [SW-1:0]                mapv_r, mapv_nxt, pos_r, pos_nxt;
  logic [PW-1:0]                prod_r, prod_nxt;
  logic                         skip_r, skip_nxt, bad_r, bad_nxt;
  logic [MW-1:0]                mean_prod;

  logic          div_start, div_busy, div_done;
  logic [PW-1:0] div_dividend, div_q;
  logic [CW-1:0] div_divisor;

  tsam_div #(.W(PW), .DW(CW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    avg_nxt   = avg_r;
    diff_nxt  = diff_r;
    den_nxt   = den_r;
    span_nxt  = span_r;
    mapv_nxt  = mapv_r;
    pos_nxt   = pos_r;
    prod_nxt  = prod_r;
    skip_nxt  = skip_r;
    bad_nxt   = bad_r;
    q_pop_o   = 1'b0;
    div_start = 1'b0;

    // The divider only runs the coordinate division.
    div_dividend = prod_r;
    div_divisor  = den_r;

    // While in BK_AVG, prod_r holds the burst sum.
    mean_prod = MW'(prod_r[SUM_W-1:0]) * MW'(RECIP);

    if (axis_r == tsam_pkg::AXIS_Y) begin
      lo       = cfg_i.y_low;
      hi       = cfg_i.y_high;
      span_sel = cfg_i.height;
    end else begin
      lo       = cfg_i.x_low;
      hi       = cfg_i.x_high;
      span_sel = cfg_i.width;
    end

    case (state_r)
      tsam_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          prod_nxt  = PW'(q_sum_i);
          axis_nxt  = q_axis_i;
          state_nxt = tsam_pkg::BK_AVG;
        end
      end
      tsam_pkg::BK_AVG: begin
        avg_nxt   = mean_prod[RSH +: tsam_pkg::SAMPLE_W];
        state_nxt = tsam_pkg::BK_MAP;
      end
      tsam_pkg::BK_MAP: begin
        bad_nxt   = (hi <= lo);
        skip_nxt  = (axis_r == tsam_pkg::AXIS_P) || (hi <= lo) || (avg_r <= lo);
        diff_nxt  = avg_r - lo;
        den_nxt   = hi - lo;
        span_nxt  = span_sel;
        state_nxt = tsam_pkg::BK_MUL;
      end
      tsam_pkg::BK_MUL: begin
        prod_nxt = PW'(diff_r) * PW'(span_r);
        if (skip_r) begin
          mapv_nxt  = '0;
          state_nxt = tsam_pkg::BK_FIN;
        end else begin
          state_nxt = tsam_pkg::BK_LAUNCH;
        end
      end
      tsam_pkg::BK_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = tsam_pkg::BK_POS;
      end
      tsam_pkg::BK_POS: begin
        if (div_done) begin
          mapv_nxt  = (div_q > PW'(span_r)) ? span_r : div_q[SW-1:0];
          state_nxt = tsam_pkg::BK_FIN;
        end
      end
      tsam_pkg::BK_FIN: begin
        if ((axis_r == tsam_pkg::AXIS_P) || bad_r) begin
          pos_nxt = '0;
        end else if (axis_r == tsam_pkg::AXIS_Y) begin
          pos_nxt = span_r - mapv_r;
        end else begin
          pos_nxt = mapv_r;
        end
        state_nxt = tsam_pkg::BK_OUT;
      end
      tsam_pkg::BK_OUT: begin
        if (out_ready) begin
          state_nxt = tsam_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = tsam_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    avg_r  <= avg_nxt;
    diff_r <= diff_nxt;
    den_r  <= den_nxt;
    span_r <= span_nxt;
    mapv_r <= mapv_nxt;
    pos_r  <= pos_nxt;
    prod_r <= prod_nxt;
    skip_r <= skip_nxt;
    bad_r  <= bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsam_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid       = (state_r == tsam_pkg::BK_OUT);
  assign out_axis        = axis_r;
  assign out_raw_average = avg_r;
  assign out_position    = pos_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsam_pkg::BK_POS) |-> (den_r != '0))
    else $error("coordinate division by zero span");

  a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tsam_pkg::BK_OUT) && (axis_r != tsam_pkg::AXIS_P)) |->
      (pos_r <= span_r))
    else $error("position above screen span");

endmodule

`default_nettype wire

[rtl/touch_sample_average_and_map.sv]
`default_nettype none

// Touch sample averaging and screen mapping. Raw 16-bit converter samples
// arrive one per input transaction, tagged with an axis (0 X, 1 Y, 2 pressure;
// code 3 counts as pressure). A transaction with in_start_req set opens a
// burst and fixes its axis; the first DISCARD samples of a burst are dropped,
// the next AVERAGE are summed, and the sample that completes the burst makes
// one result transaction: the truncated mean and, for X and Y, the calibrated
// screen coordinate clamped to 0..span (Y inverted as span minus that value;
// position 0 when the high calibration is not above the low one, and always
// for pressure). After reset a burst on X counts as already open. A start in
// mid-burst abandons the running burst; samples without a start after a
// finished burst are dropped. Input transactions are taken one per cycle as
// long as the two-entry queue of finished bursts has room, including while a
// result waits on the output. The mean comes from a multiplication by a
// reciprocal constant. After taking a finished burst from the queue, the
// back end forms the mean, sets up the mapping, multiplies, runs the
// one-bit-per-cycle divider that computes the coordinate and then offers
// the result; when the position is known without dividing (pressure, a
// mean at or below the low calibration, or a degenerate calibration) the
// divider is skipped. The back end can take the next burst in the cycle
// after the result is accepted. Calibration registers are written through
// cfg_we, cfg_index and cfg_data, one write per cycle, and must only change
// while no burst result is in flight.

module touch_sample_average_and_map #(
  parameter int DISCARD = tsam_pkg::DISCARD_DEF,
  parameter int AVERAGE = tsam_pkg::AVERAGE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tsam_pkg::AXIS_W-1:0]     in_kind,
  input  wire logic [tsam_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                            in_start_req,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [tsam_pkg::AXIS_W-1:0]          out_axis,
  output logic [tsam_pkg::SAMPLE_W-1:0]        out_raw_average,
  output logic [tsam_pkg::SPAN_W-1:0]          out_position,
  input  wire logic                            cfg_we,
  input  wire logic [tsam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsam_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = tsam_pkg::SAMPLE_W + $clog2(AVERAGE);
  localparam int Q_W   = tsam_pkg::AXIS_W + SUM_W;

  // Calibration register file.
  tsam_pkg::cal_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_low  <= tsam_pkg::X_LOW_RST;
      cfg_r.x_high <= tsam_pkg::X_HIGH_RST;
      cfg_r.y_low  <= tsam_pkg::Y_LOW_RST;
      cfg_r.y_high <= tsam_pkg::Y_HIGH_RST;
      cfg_r.width  <= tsam_pkg::WIDTH_RST;
      cfg_r.height <= tsam_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tsam_pkg::CFG_X_LOW:  cfg_r.x_low  <= cfg_data;
        tsam_pkg::CFG_X_HIGH: cfg_r.x_high <= cfg_data;
        tsam_pkg::CFG_Y_LOW:  cfg_r.y_low  <= cfg_data;
        tsam_pkg::CFG_Y_HIGH: cfg_r.y_high <= cfg_data;
        tsam_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_data[tsam_pkg::SPAN_W-1:0];
        tsam_pkg::CFG_HEIGHT: cfg_r.height <= cfg_data[tsam_pkg::SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: burst counting and summing, one transaction per cycle while the burst queue has room.
  logic                        push, q_full, q_valid, q_pop;
  logic [tsam_pkg::AXIS_W-1:0] push_axis, q_axis;
  logic [SUM_W-1:0]            push_sum, q_sum;
  logic [Q_W-1:0]              q_rd_data;

  tsam_front #(.DISCARD(DISCARD), .AVERAGE(AVERAGE)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_sample    (in_sample),
    .in_start_req (in_start_req),
    .full_i       (q_full),
    .push_o       (push),
    .push_axis_o  (push_axis),
    .push_sum_o   (push_sum)
  );

  // Finished bursts wait here for the back end.
  tsam_fifo #(.W(Q_W)) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i ({push_axis, push_sum}),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_rd_data)
  );

  assign q_axis = q_rd_data[Q_W-1:SUM_W];
  assign q_sum  = q_rd_data[SUM_W-1:0];

  // Back end: mean, calibration mapping and the result register.
  tsam_back #(.AVERAGE(AVERAGE)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg_r),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_axis_i        (q_axis),
    .q_sum_i         (q_sum),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_axis        (out_axis),
    .out_raw_average (out_raw_average),
    .out_position    (out_position)
  );

endmodule

`default_nettype wire

[tb/touch_sample_average_and_map_tb.sv]
`timescale 1ns / 100ps

module touch_sample_average_and_map_tb;
  import tsam_pkg::*;

  // A full burst is the discarded lead-in plus the averaged samples.
  localparam int BURST_LEN = DISCARD_DEF + AVERAGE_DEF;
  // The burst queue holds two finished bursts, so this settle time comfortably
  // covers any work still in flight.
  localparam int SETTLE_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [AXIS_W-1:0]   kind;
    logic [SAMPLE_W-1:0] sample;
    logic                start_req;
  } touch_sample_t;

  typedef struct packed {
    logic [AXIS_W-1:0]   axis;
    logic [SAMPLE_W-1:0] raw_average;
    logic [SPAN_W-1:0]   position;
  } touch_reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [AXIS_W-1:0]     in_kind = '0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  in_start_req = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [AXIS_W-1:0]     out_axis;
  logic [SAMPLE_W-1:0]   out_raw_average;
  logic [SPAN_W-1:0]     out_position;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  touch_sample_t  sample_queue[$];
  touch_reading_t expected_readings[$];
  touch_sample_t  next_sample;
  touch_reading_t predicted_reading;
  touch_reading_t wanted_reading;

  // The testbench's own copy of the calibration registers and burst state.
  cal_cfg_t          cal;
  int                acc_count;
  logic [18:0]       acc_sum;
  logic [AXIS_W-1:0] acc_axis;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;

  touch_sample_average_and_map dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_sample       (in_sample),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_axis        (out_axis),
    .out_raw_average (out_raw_average),
    .out_position    (out_position),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  // Linear calibration of one axis. A mean at or below the low point maps to
  // zero, a mean past the high point clamps to the span, and a degenerate
  // calibration (high not above low) always gives zero.
  function automatic logic [SPAN_W-1:0] scale_to_screen(input logic [SAMPLE_W-1:0] avg,
                                                        input logic [CAL_W-1:0] lo,
                                                        input logic [CAL_W-1:0] hi,
                                                        input logic [SPAN_W-1:0] span);
    int unsigned v;
    if (hi <= lo || avg <= lo) return '0;
    v = ((int'(avg) - int'(lo)) * int'(span)) / (int'(hi) - int'(lo));
    if (v > span) v = span;
    return v[SPAN_W-1:0];
  endfunction

  // Advances the burst state by one accepted sample. Returns 1 when this sample
  // completes a burst, with the reading that the block must then produce.
  function automatic bit predict_touch_reading(input touch_sample_t s,
                                               output touch_reading_t r);
    logic [SAMPLE_W-1:0] avg;
    logic [SPAN_W-1:0]   pos;
    r = '0;
    if (s.start_req) begin
      acc_count = 0;
      acc_sum = '0;
      // Kind three has no axis of its own and is folded into pressure.
      acc_axis = (s.kind == AXIS_X || s.kind == AXIS_Y) ? s.kind : AXIS_P;
    end else if (acc_count >= BURST_LEN) begin
      return 1'b0;
    end
    if (acc_count >= DISCARD_DEF) acc_sum = acc_sum + s.sample;
    acc_count++;
    if (acc_count < BURST_LEN) return 1'b0;
    avg = acc_sum / AVERAGE_DEF;
    case (acc_axis)
      AXIS_X: begin
        pos = scale_to_screen(avg, cal.x_low, cal.x_high, cal.width);
      end
      AXIS_Y: begin
        // Y is inverted, except that a degenerate calibration still reports 0.
        if (cal.y_high <= cal.y_low) pos = '0;
        else pos = cal.height - scale_to_screen(avg, cal.y_low, cal.y_high, cal.height);
      end
      default: begin
        pos = '0;
      end
    endcase
    r.axis = acc_axis;
    r.raw_average = avg;
    r.position = pos;
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Input driver. A new transaction is only offered once the previous one has
  // been taken, and valid is held with a stable payload until it is.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = sample_queue.pop_front();
        in_valid <= 1'b1;
        in_kind <= next_sample.kind;
        in_sample <= next_sample.sample;
        in_start_req <= next_sample.start_req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls at random according to the current idle setting.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor. Every accepted input transaction is run through the predictor, and
  // every accepted result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (predict_touch_reading({in_kind, in_sample, in_start_req}, predicted_reading))
          expected_readings.push_back(predicted_reading);
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          note_failure($sformatf("unexpected result axis=%0d avg=%0d pos=%0d",
                                 out_axis, out_raw_average, out_position));
        end else begin
          wanted_reading = expected_readings.pop_front();
          if (out_axis !== wanted_reading.axis ||
              out_raw_average !== wanted_reading.raw_average ||
              out_position !== wanted_reading.position) begin
            note_failure($sformatf("mismatch: axis exp %0d got %0d, avg exp %0d got %0d, pos exp %0d got %0d",
                                   wanted_reading.axis, out_axis,
                                   wanted_reading.raw_average, out_raw_average,
                                   wanted_reading.position, out_position));
          end
        end
      end
    end
  end

  task automatic write_cal_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_X_LOW:  cal.x_low = value;
      CFG_X_HIGH: cal.x_high = value;
      CFG_Y_LOW:  cal.y_low = value;
      CFG_Y_HIGH: cal.y_high = value;
      CFG_WIDTH:  cal.width = value[SPAN_W-1:0];
      CFG_HEIGHT: cal.height = value[SPAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_calibration(input int xl, input int xh, input int yl, input int yh,
                                 input int w, input int h);
    write_cal_reg(CFG_X_LOW, xl[CFG_DATA_W-1:0]);
    write_cal_reg(CFG_X_HIGH, xh[CFG_DATA_W-1:0]);
    write_cal_reg(CFG_Y_LOW, yl[CFG_DATA_W-1:0]);
    write_cal_reg(CFG_Y_HIGH, yh[CFG_DATA_W-1:0]);
    write_cal_reg(CFG_WIDTH, w[CFG_DATA_W-1:0]);
    write_cal_reg(CFG_HEIGHT, h[CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Each phase uses its own calibration: full-range extremes, degenerate
  // calibrations with zero spans, random and very narrow windows, reset values.
  task automatic apply_cal_set(input int sel);
    int lo;
    int lo2;
    case (sel)
      0: set_calibration(0, 65535, 0, 65535, 4095, 4095);
      1: set_calibration(20000, 20000, 30000, 1000, 0, 1);
      2: begin
        lo = $urandom_range(40000);
        lo2 = $urandom_range(40000);
        set_calibration(lo, lo + $urandom_range(25535, 1), lo2, lo2 + $urandom_range(25535, 1),
                        $urandom_range(4095, 1), $urandom_range(4095, 1));
      end
      3: begin
        lo = $urandom_range(65519);
        lo2 = $urandom_range(65519);
        set_calibration(lo, lo + $urandom_range(16, 1), lo2, lo2 + $urandom_range(16, 1),
                        4095, $urandom_range(4095, 1));
      end
      4: set_calibration(65535, 0, 0, 1, 1, 0);
      default: set_calibration(X_LOW_RST, X_HIGH_RST, Y_LOW_RST, Y_HIGH_RST,
                               WIDTH_RST, HEIGHT_RST);
    endcase
  endtask

  // Queues one burst of len samples. The samples cluster around a center so
  // that the mean lands where it matters: inside the calibration window, near
  // its edges, or at the ends of the sample range. Kind is randomized on the
  // follow-on samples since the block must ignore it there.
  task automatic queue_burst(input int len, input logic [AXIS_W-1:0] kind);
    int center;
    int spread;
    int lo;
    int hi;
    int v;
    touch_sample_t s;
    lo = (kind == AXIS_Y) ? cal.y_low : cal.x_low;
    hi = (kind == AXIS_Y) ? cal.y_high : cal.x_high;
    if (lo > hi) begin
      v = lo;
      lo = hi;
      hi = v;
    end
    case ($urandom_range(3))
      0: center = $urandom_range(65535);
      1: center = $urandom_range(hi + 1500, lo - 1500);
      2: center = $urandom_range(3000);
      default: center = 65535 - $urandom_range(3000);
    endcase
    spread = ($urandom_range(3) == 0) ? 8000 : 300;
    for (int i = 0; i < len; i++) begin
      v = center + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      s.start_req = (i == 0);
      s.kind = (i == 0) ? kind : AXIS_W'($urandom_range(3));
      s.sample = v[SAMPLE_W-1:0];
      sample_queue.push_back(s);
    end
  endtask

  // Mostly complete bursts, with some abandoned bursts and stray samples that
  // arrive without a start. Stray samples do not count toward the total.
  task automatic queue_random_traffic(input int n);
    int sent;
    int r;
    int len;
    touch_sample_t s;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        queue_burst(BURST_LEN, AXIS_W'($urandom_range(3)));
        sent += BURST_LEN;
      end else if (r < 90) begin
        len = $urandom_range(BURST_LEN - 1, 1);
        queue_burst(len, AXIS_W'($urandom_range(3)));
        sent += len;
      end else begin
        repeat ($urandom_range(3, 1)) begin
          s.start_req = 1'b0;
          s.kind = AXIS_W'($urandom_range(3));
          s.sample = SAMPLE_W'($urandom_range(65535));
          sample_queue.push_back(s);
        end
      end
    end
  endtask

  // Holds the sender back until every queued transaction is accepted and every
  // predicted result has come out, then lets the back end settle.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_sample(input logic [AXIS_W-1:0] kind, input logic [SAMPLE_W-1:0] value,
                              input logic start_req);
    sample_queue.push_back({kind, value, start_req});
  endtask

  initial begin
    cal = {X_LOW_RST, X_HIGH_RST, Y_LOW_RST, Y_HIGH_RST, WIDTH_RST, HEIGHT_RST};
    acc_count = 0;
    acc_sum = '0;
    acc_axis = AXIS_X;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 47;

    // Right after reset an X burst is already open, so plain samples fill it.
    // The lead-in alternates the sample extremes; the averaged part is all ones,
    // which drives the X coordinate past the top of the window.
    for (int i = 0; i < DISCARD_DEF; i++)
      queue_sample(AXIS_W'(i % 4), (i % 2) ? '1 : '0, 1'b0);
    for (int i = 0; i < AVERAGE_DEF; i++)
      queue_sample(AXIS_W'(i % 4), '1, 1'b0);
    // A plain sample after a finished burst is dropped.
    queue_sample(AXIS_Y, 16'h5A5A, 1'b0);
    // A Y burst is started and then abandoned by a new start of kind three,
    // which runs as a pressure burst even though the kind changes underneath.
    queue_sample(AXIS_Y, 16'h1234, 1'b1);
    queue_sample(AXIS_X, 16'hFFFF, 1'b0);
    queue_sample(AXIS_P, 16'h0001, 1'b0);
    queue_sample(AXIS_W'(3), 16'hFFFF, 1'b1);
    for (int i = 1; i < BURST_LEN; i++)
      queue_sample(AXIS_W'(i % 4), (i < DISCARD_DEF) ? 16'hFFFF : 16'h0000, 1'b0);
    wait_until_idle();

    // Random traffic in three idle regimes, two calibrations each. Every phase
    // ends with the sender held back until the block has fully drained.
    for (int mode = 0; mode < 3; mode++) begin
      for (int half = 0; half < 2; half++) begin
        case (mode)
          0: begin
            send_idle_pct = 31;
            recv_idle_pct = 47;
          end
          1: begin
            send_idle_pct = 47;
            recv_idle_pct = 31;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        apply_cal_set(mode * 2 + half);
        queue_random_traffic(ITEMS_PER_PHASE);
        wait_until_idle();
      end
    end

    if (expected_readings.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_readings.size()));
    if (fail_count == 0) begin
      $display("touch_sample_average_and_map test passed");
    end else begin
      $display("touch_sample_average_and_map test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #1000000;
    $display("touch_sample_average_and_map test failed");
    $finish;
  end

endmodule
